### rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Sorted secondary index table package
// Types and codes shared by the table's cell row and its control.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned COUNT_W = 7;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_RANGE  = 2'd1,
      REQ_FLUSH  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key_lo;
      logic [KEY_W-1:0] primary_key;
      logic [KEY_W-1:0] key_hi;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0]   out_key;
      logic [KEY_W-1:0]   out_value;
      logic               valid_res;
      logic               last;
      logic               refused;
      logic [COUNT_W-1:0] entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             insert;
      logic             rotate;
      logic [KEY_W-1:0] key_lo;
      entry_type        new_entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### rtl/sit_cell.sv
// ----------------------------------------------------------------------------
// Sorted index cell
// Holds one entry; shifts right on insert and rotates left during scans.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cell (
   input  wire logic                  clock,
   input  wire sit_pkg::cell_ctrl_type ctrl,
   input  wire logic                  occupied,
   input  wire logic                  wrap,
   input  wire logic                  left_take,
   input  wire sit_pkg::entry_type    left_entry,
   input  wire sit_pkg::entry_type    right_entry,
   input  wire sit_pkg::entry_type    head_entry,
   output sit_pkg::entry_type         entry,
   output logic                       take
);

   sit_pkg::entry_type entry_ff;
   sit_pkg::entry_type entry_in;

   assign take  = !occupied || (entry_ff.key >= ctrl.key_lo);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (left_take) begin
            entry_in = left_entry;
         end else if (take) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.rotate) begin
         entry_in = wrap ? head_entry : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

### rtl/sorted_secondary_index_table_top.sv
// ----------------------------------------------------------------------------
// Sorted secondary index table
// Bounded table of (key, primary key) pairs held sorted in a row of cells.
// ----------------------------------------------------------------------------
//  Channel   Ports                        Transfer when
//  request   start, busy, req_data        start high and busy low
//  response  rsp_strobe, rsp_data         rsp_strobe high (one cycle each)
//
// Insert and clear finish when accepted; their response appears the next cycle.
// Range query and flush scan every stored entry in turn, since the
// cell row rotates once past the head cell and comes back to its order.
// An empty table answers a query or flush without a scan.
// Reset empties the table and returns the control to idle.
// The receiver cannot stall; each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_secondary_index_table_top #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire sit_pkg::req_payload_type req_data,
   output logic                         rsp_strobe,
   output sit_pkg::rsp_payload_type     rsp_data
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam logic [sit_pkg::COUNT_W-1:0] CAP_COUNT = sit_pkg::COUNT_W'(CAPACITY);

   sit_pkg::state_type state_ff, state_in;
   logic [sit_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic done_ff, done_in;
   logic flush_ff, flush_in;
   logic [sit_pkg::KEY_W-1:0] lo_ff, lo_in;
   logic [sit_pkg::KEY_W-1:0] hi_ff, hi_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   sit_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   sit_pkg::cell_ctrl_type ctrl;
   sit_pkg::entry_type entries [CAPACITY];
   logic takes [CAPACITY];

   logic accept;
   logic scan_end;
   logic in_range;
   logic emit;
   logic emit_last;

   assign accept = start && (state_ff == sit_pkg::ST_IDLE);
   assign busy   = (state_ff == sit_pkg::ST_SCAN);

   assign ctrl.insert = accept && (req_data.req_type == sit_pkg::REQ_INSERT)
                        && (count_ff != CAP_COUNT);
   assign ctrl.rotate = (state_ff == sit_pkg::ST_SCAN);
   assign ctrl.key_lo = req_data.key_lo;
   assign ctrl.new_entry.key   = req_data.key_lo;
   assign ctrl.new_entry.value = req_data.primary_key;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [sit_pkg::COUNT_W-1:0] IDX = sit_pkg::COUNT_W'(i);
      sit_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (IDX < count_ff),
         .wrap       (IDX == count_ff - sit_pkg::COUNT_W'(1)),
         .left_take  ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i - 1]),
         .left_entry ((i == 0) ? ctrl.new_entry : entries[(i == 0) ? 0 : i - 1]),
         .right_entry(entries[(i == CAPACITY - 1) ? 0 : i + 1]),
         .head_entry (entries[0]),
         .entry      (entries[i]),
         .take       (takes[i])
      );
   end

   assign scan_end  = ({{(sit_pkg::COUNT_W - IDX_W){1'b0}}, idx_ff}
                       == count_ff - sit_pkg::COUNT_W'(1));
   assign in_range  = flush_ff || ((entries[0].key >= lo_ff) && (entries[0].key <= hi_ff));
   assign emit      = in_range && !done_ff;
   assign emit_last = scan_end || (!flush_ff && (entries[1].key > hi_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      done_in       = done_ff;
      flush_in      = flush_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in.out_key     = '0;
      rsp_data_in.out_value   = '0;
      rsp_data_in.valid_res   = 1'b0;
      rsp_data_in.last        = 1'b1;
      rsp_data_in.refused     = 1'b0;
      rsp_data_in.entry_count = count_ff;
      case (state_ff)
         sit_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  sit_pkg::REQ_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == CAP_COUNT) begin
                        rsp_data_in.refused = 1'b1;
                     end else begin
                        count_in = count_ff + sit_pkg::COUNT_W'(1);
                        rsp_data_in.entry_count = count_in;
                     end
                  end
                  sit_pkg::REQ_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     count_in = '0;
                     rsp_data_in.entry_count = '0;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = sit_pkg::ST_SCAN;
                        idx_in   = '0;
                        found_in = 1'b0;
                        done_in  = 1'b0;
                        flush_in = (req_data.req_type == sit_pkg::REQ_FLUSH);
                        lo_in    = req_data.key_lo;
                        hi_in    = req_data.key_hi;
                     end
                  end
               endcase
            end
         end
         sit_pkg::ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (emit) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in.out_key   = entries[0].key;
               rsp_data_in.out_value = entries[0].value;
               rsp_data_in.valid_res = 1'b1;
               rsp_data_in.last      = emit_last;
               found_in = 1'b1;
               done_in  = emit_last;
            end else if (scan_end && !found_ff) begin
               rsp_strobe_in = 1'b1;
            end
            if (scan_end) begin
               state_in = sit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sit_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      done_ff     <= done_in;
      flush_ff    <= flush_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire
